FILE: rtl/tbt_pkg.sv
// shared widths, constants, status codes and pipeline types for the
// thermistor beta temperature core; no dependencies
package tbt_pkg;

    localparam int BETA_W     = 14;
    localparam int RES_W      = 20;
    localparam int RT_W       = 16;
    localparam int ADC_W      = 16;
    localparam int TEMP_W     = 16;
    localparam int STATUS_W   = 2;

    localparam int LOG_INT_W  = 8;
    localparam int LOG_FRAC_W = 24;
    localparam int LOG_W      = LOG_INT_W + LOG_FRAC_W;
    localparam int MANT_W     = 32;

    localparam int SCALE_W    = BETA_W + 7;
    localparam int BT_N_W     = SCALE_W + LOG_FRAC_W;
    localparam int BT_Q_W     = BT_N_W;
    localparam int SUM_W      = BT_N_W + 1;
    localparam int LN_W       = MANT_W + 1;
    localparam int TK_N_W     = SUM_W;
    localparam int TK_Q_W     = 17;

    localparam logic [MANT_W-1:0]       LN2_Q32       = 32'd2977044472;
    localparam logic [6:0]              CENTI         = 7'd100;
    localparam logic [TK_Q_W-1:0]       KELVIN_OFFSET = 17'd27300;
    localparam logic [TK_Q_W-1:0]       TK_MAX        = 17'd60067;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX     = 16'sd32767;
    localparam logic signed [TEMP_W-1:0] TEMP_MIN     = -16'sd27300;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

    localparam logic [1:0] REG_BETA     = 2'd0;
    localparam logic [1:0] REG_SERIES   = 2'd1;
    localparam logic [1:0] REG_NOMINAL  = 2'd2;
    localparam logic [1:0] REG_REF_TEMP = 2'd3;

    typedef struct packed {
        logic                valid;
        logic                special;
        logic                sat_high;
        logic [STATUS_W-1:0] status;
    } ctrl_t;

    typedef struct packed {
        logic sum_pos;
        logic ovf;
    } range_t;

endpackage

FILE: rtl/tbt_log2.sv
// pipelined base-2 logarithm in unsigned Q8.24: staged normalizing shift,
// then one squaring stage per fraction bit; uses tbt_pkg
module tbt_log2 import tbt_pkg::*; #(
    parameter int NORM_W = 44
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [NORM_W-1:0] value,
    output logic [LOG_W-1:0]  log_q
);

    localparam int SH_STEPS = $clog2(NORM_W);
    localparam int LZ_W     = SH_STEPS;

    logic [NORM_W-1:0]    norm_reg [SH_STEPS];
    logic [LZ_W-1:0]      lz_reg   [SH_STEPS];
    logic [MANT_W-1:0]    m_reg    [LOG_FRAC_W];
    logic [LOG_FRAC_W-1:0] frac_reg [LOG_FRAC_W];
    logic [LOG_INT_W-1:0] pos_reg  [LOG_FRAC_W];

    for (genvar k = 0; k < SH_STEPS; k++) begin : g_norm
        localparam int SH = 1 << (SH_STEPS - 1 - k);
        logic [NORM_W-1:0] v_in;
        logic [LZ_W-1:0]   lz_in;
        if (k == 0) begin : g_first
            assign v_in  = value;
            assign lz_in = '0;
        end else begin : g_rest
            assign v_in  = norm_reg[k-1];
            assign lz_in = lz_reg[k-1];
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                if (v_in[NORM_W-1 -: SH] == '0) begin
                    norm_reg[k] <= v_in << SH;
                    lz_reg[k]   <= lz_in + LZ_W'(SH);
                end else begin
                    norm_reg[k] <= v_in;
                    lz_reg[k]   <= lz_in;
                end
            end
        end
    end

    for (genvar j = 0; j < LOG_FRAC_W; j++) begin : g_sq
        logic [MANT_W-1:0]     m_in;
        logic [LOG_FRAC_W-1:0] frac_in;
        logic [LOG_INT_W-1:0]  pos_in;
        logic [2*MANT_W-1:0]   prod;
        logic [MANT_W:0]       sq;
        if (j == 0) begin : g_first
            assign m_in    = norm_reg[SH_STEPS-1][NORM_W-1 -: MANT_W];
            assign frac_in = '0;
            assign pos_in  = LOG_INT_W'(NORM_W - 1) - LOG_INT_W'(lz_reg[SH_STEPS-1]);
        end else begin : g_rest
            assign m_in    = m_reg[j-1];
            assign frac_in = frac_reg[j-1];
            assign pos_in  = pos_reg[j-1];
        end
        assign prod = (2*MANT_W)'(m_in) * (2*MANT_W)'(m_in);
        assign sq   = prod[2*MANT_W-1 -: MANT_W+1];
        always_ff @(posedge aclk) begin
            if (en) begin
                pos_reg[j] <= pos_in;
                if (sq[MANT_W]) begin
                    m_reg[j]    <= sq[MANT_W:1];
                    frac_reg[j] <= {frac_in[LOG_FRAC_W-2:0], 1'b1};
                end else begin
                    m_reg[j]    <= sq[MANT_W-1:0];
                    frac_reg[j] <= {frac_in[LOG_FRAC_W-2:0], 1'b0};
                end
            end
        end
    end

    assign log_q = {pos_reg[LOG_FRAC_W-1], frac_reg[LOG_FRAC_W-1]};

endmodule

FILE: rtl/tbt_div.sv
// pipelined restoring divider, one quotient bit per stage; the quotient
// must fit in Q_W bits; uses tbt_pkg for the house conventions only
module tbt_div import tbt_pkg::*; #(
    parameter int N_W = 46,
    parameter int D_W = 46,
    parameter int Q_W = 17
) (
    input  logic           aclk,
    input  logic           en,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic [Q_W-1:0] quotient
);

    localparam int ACC_W = D_W + Q_W;

    logic [ACC_W-1:0] acc_reg [Q_W];
    logic [D_W-1:0]   d_reg   [Q_W-1];

    for (genvar i = 0; i < Q_W; i++) begin : g_step
        logic [ACC_W-1:0] acc_in;
        logic [D_W-1:0]   d_in;
        logic [ACC_W:0]   shifted;
        logic [D_W:0]     top;
        logic             ge;
        if (i == 0) begin : g_first
            assign acc_in = ACC_W'(dividend);
            assign d_in   = divisor;
        end else begin : g_rest
            assign acc_in = acc_reg[i-1];
            assign d_in   = d_reg[i-1];
        end
        assign shifted = {acc_in, 1'b0};
        assign top     = shifted[ACC_W:Q_W];
        assign ge      = top >= {1'b0, d_in};
        always_ff @(posedge aclk) begin
            if (en) begin
                if (ge) begin
                    acc_reg[i] <= {D_W'(top - {1'b0, d_in}), shifted[Q_W-1:1], 1'b1};
                end else begin
                    acc_reg[i] <= {top[D_W-1:0], shifted[Q_W-1:1], 1'b0};
                end
            end
        end
        if (i < Q_W - 1) begin : g_carry
            always_ff @(posedge aclk) begin
                if (en) begin
                    d_reg[i] <= d_in;
                end
            end
        end
    end

    assign quotient = acc_reg[Q_W-1][Q_W-1:0];

endmodule

FILE: rtl/thermistor_beta_temperature_core.sv
// Thermistor temperature by the beta equation. Takes one converter word per
// clock and returns one word per clock while the output is not stalled
// (temperature in signed hundredths of a degree C plus a status code). It has
// 64 pipeline stages set by the 45-stage divider for beta over ref_temp, two
// summing stages and the 17-stage final divider, then the output register.
// The log path (normalizing shift and 24 squaring stages per log) runs beside
// the first divider. Registers are read live by the entry stage and the
// final dividend stage, so write them only while no word is in flight. A
// stalled output stops the pipeline only once its last stage holds a word.
// depends on tbt_pkg, tbt_log2, tbt_div
module thermistor_beta_temperature_core import tbt_pkg::*; #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 4
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [ADC_W-1:0]         s_adc_reading,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [TEMP_W-1:0] m_temp_centi_c,
    output logic [STATUS_W-1:0]      m_status,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int FULL_W    = ADC_BITS + FRAC_BITS;
    localparam int CMP_W     = (FULL_W > ADC_W) ? FULL_W : ADC_W;
    localparam int NUM_W     = ADC_W + RES_W;
    localparam int DEN_W     = FULL_W + RES_W;
    localparam int NORM_W    = (NUM_W > DEN_W) ? NUM_W : DEN_W;
    localparam int LOG_LAT   = $clog2(NORM_W) + LOG_FRAC_W;
    localparam int LN_DLY    = BT_Q_W - 4 - LOG_LAT;
    localparam int TOTAL_LAT = BT_Q_W + 2 + TK_Q_W;
    localparam logic [FULL_W-1:0] FULL_SCALE =
        FULL_W'(((64'd1 << ADC_BITS) - 64'd1) << FRAC_BITS);

    logic [BETA_W-1:0] beta_reg;
    logic [RES_W-1:0]  series_reg;
    logic [RES_W-1:0]  nominal_reg;
    logic [RT_W-1:0]   ref_temp_reg;

    logic en;
    logic out_load;
    logic last_valid;

    // config port
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            beta_reg     <= BETA_W'(3380);
            series_reg   <= RES_W'(10000);
            nominal_reg  <= RES_W'(10000);
            ref_temp_reg <= RT_W'(29800);
        end else if (psel && penable && pwrite) begin
            unique case (paddr[3:2])
                REG_BETA:     beta_reg     <= pwdata[BETA_W-1:0];
                REG_SERIES:   series_reg   <= pwdata[RES_W-1:0];
                REG_NOMINAL:  nominal_reg  <= pwdata[RES_W-1:0];
                REG_REF_TEMP: ref_temp_reg <= pwdata[RT_W-1:0];
                default:      ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_BETA:     prdata = 32'(beta_reg);
            REG_SERIES:   prdata = 32'(series_reg);
            REG_NOMINAL:  prdata = 32'(nominal_reg);
            REG_REF_TEMP: prdata = 32'(ref_temp_reg);
            default:      prdata = '0;
        endcase
    end

    // entry: special cases and the products fed to the logs
    ctrl_t             entry_ctrl;
    logic [NUM_W-1:0]  num_next;
    logic [DEN_W-1:0]  den_next;
    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [SCALE_W-1:0] scale;

    assign scale = SCALE_W'(beta_reg) * SCALE_W'(CENTI);

    always_comb begin
        entry_ctrl.valid    = s_valid;
        entry_ctrl.special  = 1'b1;
        entry_ctrl.sat_high = 1'b1;
        entry_ctrl.status   = STATUS_RANGE;
        if (CMP_W'(s_adc_reading) >= CMP_W'(FULL_SCALE)) begin
            entry_ctrl.sat_high = 1'b0;
            entry_ctrl.status   = STATUS_FULL;
        end else if (s_adc_reading == '0) begin
            entry_ctrl.status   = STATUS_ZERO;
        end else if (series_reg == '0) begin
            entry_ctrl.status   = STATUS_RANGE;
        end else if (nominal_reg == '0 || ref_temp_reg == '0) begin
            entry_ctrl.sat_high = 1'b0;
        end else begin
            entry_ctrl.special  = 1'b0;
            entry_ctrl.status   = STATUS_OK;
        end
    end

    assign num_next = NUM_W'(s_adc_reading) * NUM_W'(series_reg);
    assign den_next = DEN_W'(FULL_SCALE - FULL_W'(s_adc_reading)) * DEN_W'(nominal_reg);

    always_ff @(posedge aclk) begin
        if (en) begin
            num_reg <= num_next;
            den_reg <= den_next;
        end
    end

    // logs of numerator and denominator
    logic [LOG_W-1:0] log_num;
    logic [LOG_W-1:0] log_den;

    tbt_log2 #(.NORM_W(NORM_W)) u_log_num (
        .aclk  (aclk),
        .en    (en),
        .value (NORM_W'(num_reg)),
        .log_q (log_num)
    );

    tbt_log2 #(.NORM_W(NORM_W)) u_log_den (
        .aclk  (aclk),
        .en    (en),
        .value (NORM_W'(den_reg)),
        .log_q (log_den)
    );

    // natural log: difference, times ln2, rounded magnitude
    logic [LOG_W:0]      l2_diff;
    logic                lsign_a_reg;
    logic [MANT_W-1:0]   lmag_reg;
    logic                lsign_b_reg;
    logic [2*MANT_W-1:0] lprod_reg;
    logic [2*MANT_W-1:0] lprod_rnd;
    logic [LN_W-1:0]     ln_reg;
    logic [LN_W-1:0]     ln_dly_reg [LN_DLY];

    assign l2_diff   = {1'b0, log_num} - {1'b0, log_den};
    assign lprod_rnd = lprod_reg + (2*MANT_W)'(64'h8000_0000);

    always_ff @(posedge aclk) begin
        if (en) begin
            lsign_a_reg <= l2_diff[LOG_W];
            lmag_reg    <= l2_diff[LOG_W] ? MANT_W'(-l2_diff) : l2_diff[MANT_W-1:0];
            lsign_b_reg <= lsign_a_reg;
            lprod_reg   <= (2*MANT_W)'(lmag_reg) * (2*MANT_W)'(LN2_Q32);
            ln_reg      <= lsign_b_reg ? -{1'b0, lprod_rnd[2*MANT_W-1:MANT_W]}
                                       : {1'b0, lprod_rnd[2*MANT_W-1:MANT_W]};
            ln_dly_reg[0] <= ln_reg;
            for (int i = 1; i < LN_DLY; i++) begin
                ln_dly_reg[i] <= ln_dly_reg[i-1];
            end
        end
    end

    // beta over ref_temp
    logic [BT_Q_W-1:0] bt_q;

    tbt_div #(.N_W(BT_N_W), .D_W(RT_W), .Q_W(BT_Q_W)) u_div_bt (
        .aclk     (aclk),
        .en       (en),
        .dividend ({scale, {(LOG_FRAC_W - RT_W + 1){1'b0}}, ref_temp_reg[RT_W-1:1]}),
        .divisor  (ref_temp_reg),
        .quotient (bt_q)
    );

    // sum and final dividend
    logic [SUM_W:0]    sum_reg;
    logic [TK_N_W-1:0] dividend_reg;
    logic [SUM_W-1:0]  divisor_reg;
    logic              sum_pos_reg;
    range_t            range_next;
    range_t            range_reg [TK_Q_W];
    logic [TK_Q_W-1:0] tk_q;

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg      <= {{(SUM_W + 1 - LN_W){ln_dly_reg[LN_DLY-1][LN_W-1]}},
                             ln_dly_reg[LN_DLY-1]} + {2'b00, bt_q};
            sum_pos_reg  <= !sum_reg[SUM_W] && (sum_reg != '0);
            divisor_reg  <= sum_reg[SUM_W-1:0];
            dividend_reg <= TK_N_W'({scale, {LOG_FRAC_W{1'b0}}}) +
                            TK_N_W'(sum_reg[SUM_W-1:1]);
        end
    end

    assign range_next.sum_pos = sum_pos_reg;
    assign range_next.ovf     = {{TK_Q_W{1'b0}}, dividend_reg} >=
                                {divisor_reg, {TK_Q_W{1'b0}}};

    always_ff @(posedge aclk) begin
        if (en) begin
            range_reg[0] <= range_next;
            for (int i = 1; i < TK_Q_W; i++) begin
                range_reg[i] <= range_reg[i-1];
            end
        end
    end

    tbt_div #(.N_W(TK_N_W), .D_W(SUM_W), .Q_W(TK_Q_W)) u_div_tk (
        .aclk     (aclk),
        .en       (en),
        .dividend (dividend_reg),
        .divisor  (divisor_reg),
        .quotient (tk_q)
    );

    // control travels beside the data
    ctrl_t ctrl_reg [TOTAL_LAT];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TOTAL_LAT; i++) begin
                ctrl_reg[i] <= '0;
            end
        end else if (en) begin
            ctrl_reg[0] <= entry_ctrl;
            for (int i = 1; i < TOTAL_LAT; i++) begin
                ctrl_reg[i] <= ctrl_reg[i-1];
            end
        end
    end

    // result and output register
    ctrl_t                     last_ctrl;
    range_t                    last_range;
    logic signed [TEMP_W-1:0]  temp_next;
    logic [STATUS_W-1:0]       status_next;
    logic                      m_valid_reg;
    logic signed [TEMP_W-1:0]  m_temp_reg;
    logic [STATUS_W-1:0]       m_status_reg;

    assign last_ctrl  = ctrl_reg[TOTAL_LAT-1];
    assign last_range = range_reg[TK_Q_W-1];
    assign last_valid = last_ctrl.valid;

    always_comb begin
        if (last_ctrl.special) begin
            temp_next   = last_ctrl.sat_high ? TEMP_MAX : TEMP_MIN;
            status_next = last_ctrl.status;
        end else if (!last_range.sum_pos || last_range.ovf || tk_q > TK_MAX) begin
            temp_next   = TEMP_MAX;
            status_next = STATUS_RANGE;
        end else begin
            temp_next   = TEMP_W'(tk_q - KELVIN_OFFSET);
            status_next = STATUS_OK;
        end
    end

    assign out_load = !m_valid_reg || m_ready;
    assign en       = out_load || !last_valid;
    assign s_ready  = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= last_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_temp_reg   <= temp_next;
            m_status_reg <= status_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_temp_centi_c = m_temp_reg;
    assign m_status       = m_status_reg;

    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && last_valid))
        else $error("input stalled while pipeline could advance");

    a_pipe_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (last_valid && m_valid && !m_ready) |=> $stable(ctrl_reg[TOTAL_LAT-1]))
        else $error("last stage changed while output was blocked");

    a_ok_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_OK) |-> (m_temp_centi_c >= TEMP_MIN))
        else $error("ok word below absolute zero");

    a_full_is_min: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STATUS_FULL) |-> (m_temp_centi_c == TEMP_MIN))
        else $error("full scale word not saturated low");

endmodule
